// ===== hw/rtl/thread_table_scheduler_core_assert.svh =====
// Assertion helpers for the scheduler core.
`ifndef THREAD_TABLE_SCHEDULER_CORE_ASSERT_SVH
`define THREAD_TABLE_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define TTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define TTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tts_pkg.sv =====
package tts_pkg;

   // table size default
   localparam int DEF_MAX_ENTRIES = 16;

   // config register reset values
   localparam logic [63:0] KERNEL_ROOT_RESET = 64'h0;
   localparam logic [63:0] BOOT_STACK_RESET  = 64'h0000_0000_0009_F000;

   // config address: two 64-bit registers at 0 and 8
   localparam int CSR_ADDR_W = 4;
   localparam logic CSR_KERNEL_ROOT = 1'b0;
   localparam logic CSR_BOOT_STACK  = 1'b1;

   // op codes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_IRQ     = 3'd1;
   localparam logic [2:0] OP_BLOCK   = 3'd2;
   localparam logic [2:0] OP_UNBLOCK = 3'd3;
   localparam logic [2:0] OP_EXIT    = 3'd4;
   localparam logic [2:0] OP_ADD     = 3'd5;

   // per-thread state
   typedef enum logic [1:0] {
      TS_READY      = 2'd0,
      TS_RUNNING    = 2'd1,
      TS_BLOCKED    = 2'd2,
      TS_TERMINATED = 2'd3
   } thr_state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] current_context;
      logic [63:0] new_context;
      logic [63:0] new_stack_top;
      logic [63:0] new_space_root;
   } req_item_type;

   typedef struct packed {
      logic        switched;
      logic [3:0]  thread_index;
      logic [63:0] resume_context;
      logic [63:0] kernel_stack;
      logic [63:0] space_root;
      logic        status;
      logic [4:0]  thread_count;
   } rsp_item_type;

   // config values seen by the datapath
   typedef struct packed {
      logic [63:0] kernel_root;
      logic [63:0] boot_stack_top;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic exec;
   } cmd_type;

endpackage

// ===== hw/rtl/thread_table_scheduler_core.sv =====
// Channel   Dir  Handshake               Beat
// req       in   req_valid / req_stall   req_item_type (op and context fields)
// rsp       out  rsp_valid / rsp_stall   rsp_item_type (switch, index, context)
// csr       in   psel/penable/pwrite     64-bit kernel_root at 0, boot_stack_top at 8
//
// One item at a time: the accept edge runs the whole table update and the
// registered entry-memory read; the result beat is valid the next cycle.
// A new item is taken only once the result beat has left, so rsp_stall adds
// its cycles directly. Thread pick is a combinational priority encoder over the state flops.
// Reset is synchronous; no memory clearing pass is needed.
`include "thread_table_scheduler_core_assert.svh"

module thread_table_scheduler_core
   import tts_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   cmd_type cmd;
   cfg_type cfg;

   assign pready = 1'b1;

   tts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tts_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   // checks
   `TTS_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, cmd.exec, rsp_valid, "no result after accept")
   `TTS_ASSERT_IMPL(a_no_accept_pending, clock, reset, rsp_valid, req_stall, "accept while result pending")
   `TTS_ASSERT_IMPL(a_noswitch_zero, clock, reset, rsp_valid && !rsp_item.switched, (rsp_item.resume_context == 64'd0) && (rsp_item.space_root == 64'd0), "context given without switch")
   `TTS_ASSERT_IMPL(a_refuse_noswitch, clock, reset, rsp_valid && rsp_item.status, !rsp_item.switched, "refused add reports a switch")

endmodule

// ===== hw/rtl/tts_csr.sv =====
module tts_csr
   import tts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output cfg_type               cfg
);

   logic [63:0] kernel_root_ff;
   logic [63:0] boot_stack_ff;
   logic        wr_en;
   logic        sel;

   assign wr_en = psel & penable & pwrite;
   assign sel   = paddr[3];

   // register writes on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_root_ff <= KERNEL_ROOT_RESET;
         boot_stack_ff  <= BOOT_STACK_RESET;
      end else if (wr_en) begin
         if (sel == CSR_BOOT_STACK) begin
            boot_stack_ff <= pwdata;
         end else begin
            kernel_root_ff <= pwdata;
         end
      end
   end

   assign prdata = (sel == CSR_KERNEL_ROOT) ? kernel_root_ff : boot_stack_ff;

   assign cfg.kernel_root    = kernel_root_ff;
   assign cfg.boot_stack_top = boot_stack_ff;

endmodule

// ===== hw/rtl/tts_ctrl.sv =====
module tts_ctrl
   import tts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RESP = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // handshake and command outputs
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.exec  = (state_ff == ST_IDLE) && req_valid;

endmodule

// ===== hw/rtl/tts_dp.sv =====
module tts_dp
   import tts_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  cfg_type      cfg,
   input  req_item_type req_item,
   output rsp_item_type rsp_item
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // thread table state
   thr_state_type    st_ff [MAX_ENTRIES];
   thr_state_type    st_in [MAX_ENTRIES];
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sw_ff, sw_in;
   logic             status_ff, status_in;

   // entry memories
   logic [63:0] ctx_mem  [MAX_ENTRIES];
   logic [63:0] stk_mem  [MAX_ENTRIES];
   logic [63:0] root_mem [MAX_ENTRIES];
   logic [63:0] rd_ctx_ff, rd_stk_ff, rd_root_ff;

   // memory write controls
   logic             ctx_we;
   logic [IDX_W-1:0] ctx_waddr;
   logic [63:0]      ctx_wdata;
   logic             tab_we;
   logic [IDX_W-1:0] add_idx;
   logic             ctx_fwd;

   // pick logic
   logic                   multi;
   logic                   cur_run;
   thr_state_type          tk_mod_st;
   thr_state_type          tk_cur_st;
   logic [MAX_ENTRIES-1:0] in_rng;
   logic [MAX_ENTRIES-1:0] rdy_base;
   logic [MAX_ENTRIES-1:0] rdy_tick;
   logic [MAX_ENTRIES-1:0] tk_hi;
   logic [MAX_ENTRIES-1:0] mid_rdy;
   logic                   tk_found;
   logic [IDX_W-1:0]       tk_pick;
   logic [IDX_W-1:0]       irq_best;
   logic                   irq_sw;

   function automatic logic [IDX_W-1:0] first_set(input logic [MAX_ENTRIES-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   assign multi   = (cnt_ff > CNT_W'(1));
   assign cur_run = (st_ff[cur_ff] == TS_RUNNING);
   assign add_idx = cnt_ff[IDX_W-1:0];

   // current entry state as the tick scan sees it
   always_comb begin
      case (req_item.op)
         OP_BLOCK: tk_mod_st = TS_BLOCKED;
         OP_EXIT:  tk_mod_st = TS_TERMINATED;
         default:  tk_mod_st = st_ff[cur_ff];
      endcase
      tk_cur_st = (tk_mod_st == TS_RUNNING) ? TS_READY : tk_mod_st;
   end

   // ready masks
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         in_rng[i]   = (CNT_W'(i) < cnt_ff);
         rdy_base[i] = in_rng[i] && (st_ff[i] == TS_READY);
         rdy_tick[i] = (IDX_W'(i) == cur_ff) ? (in_rng[i] && (tk_cur_st == TS_READY))
                                             : rdy_base[i];
         tk_hi[i]    = rdy_tick[i] && (IDX_W'(i) > cur_ff);
         mid_rdy[i]  = rdy_base[i] && (i >= 2);
      end
   end

   // round-robin: first ready above current, else wrap to the lowest
   assign tk_found = |rdy_tick;
   assign tk_pick  = (|tk_hi) ? first_set(tk_hi) : first_set(rdy_tick);

   // fixed priority: index 1 highest, index 0 lowest
   always_comb begin
      if (rdy_base[1] && !(cur_run && (cur_ff == IDX_W'(1)))) begin
         irq_best = IDX_W'(1);
      end else if ((|mid_rdy) && !(cur_run && (cur_ff != '0))) begin
         irq_best = first_set(mid_rdy);
      end else if (cur_run) begin
         irq_best = cur_ff;
      end else begin
         irq_best = '0;
      end
   end
   assign irq_sw = (irq_best != cur_ff);

   // operation decode and next state
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) st_in[i] = st_ff[i];
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      sw_in     = 1'b0;
      status_in = 1'b0;
      ctx_we    = 1'b0;
      ctx_waddr = cur_ff;
      ctx_wdata = req_item.current_context;
      tab_we    = 1'b0;
      if (cmd.exec) begin
         case (req_item.op)
            OP_TICK, OP_BLOCK, OP_EXIT: begin
               st_in[cur_ff] = tk_mod_st;
               if (multi) begin
                  ctx_we        = 1'b1;
                  st_in[cur_ff] = tk_cur_st;
                  if (tk_found) begin
                     st_in[tk_pick] = TS_RUNNING;
                     cur_in         = tk_pick;
                     sw_in          = 1'b1;
                  end else begin
                     st_in[cur_ff] = TS_RUNNING;
                  end
               end
            end
            OP_IRQ: begin
               if (multi && irq_sw) begin
                  ctx_we = 1'b1;
                  if (cur_run) st_in[cur_ff] = TS_READY;
                  st_in[irq_best] = TS_RUNNING;
                  cur_in          = irq_best;
                  sw_in           = 1'b1;
               end
            end
            OP_UNBLOCK: begin
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (in_rng[i] && (st_ff[i] == TS_BLOCKED)) st_in[i] = TS_READY;
               end
            end
            OP_ADD: begin
               if (cnt_ff >= CNT_W'(MAX_ENTRIES)) begin
                  status_in = 1'b1;
               end else begin
                  ctx_we         = 1'b1;
                  ctx_waddr      = add_idx;
                  ctx_wdata      = req_item.new_context;
                  tab_we         = 1'b1;
                  st_in[add_idx] = TS_READY;
                  cnt_in         = cnt_ff + CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // a context saved this beat is read back at the same address
   assign ctx_fwd = ctx_we && (ctx_waddr == cur_in);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            st_ff[i] <= (i == 0) ? TS_RUNNING : TS_READY;
         end
         cur_ff <= '0;
         cnt_ff <= CNT_W'(1);
      end else if (cmd.exec) begin
         for (int i = 0; i < MAX_ENTRIES; i++) st_ff[i] <= st_in[i];
         cur_ff <= cur_in;
         cnt_ff <= cnt_in;
      end
   end

   // result flags
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         sw_ff     <= sw_in;
         status_ff <= status_in;
      end
   end

   // context memory: save or add write, read of the new current entry
   always_ff @(posedge clock) begin
      if (ctx_we) ctx_mem[ctx_waddr] <= ctx_wdata;
      if (cmd.exec) rd_ctx_ff <= ctx_fwd ? ctx_wdata : ctx_mem[cur_in];
   end

   // stack and root memories: written on add only
   always_ff @(posedge clock) begin
      if (tab_we) begin
         stk_mem[add_idx]  <= req_item.new_stack_top;
         root_mem[add_idx] <= req_item.new_space_root;
      end
      if (cmd.exec) begin
         rd_stk_ff  <= stk_mem[cur_in];
         rd_root_ff <= root_mem[cur_in];
      end
   end

   // result beat; entry 0 takes stack and root from config
   always_comb begin
      rsp_item.switched       = sw_ff;
      rsp_item.thread_index   = 4'(cur_ff);
      rsp_item.resume_context = sw_ff ? rd_ctx_ff : 64'd0;
      rsp_item.kernel_stack   = (cur_ff == '0) ? cfg.boot_stack_top : rd_stk_ff;
      rsp_item.space_root     = sw_ff ? ((cur_ff == '0) ? cfg.kernel_root : rd_root_ff)
                                      : 64'd0;
      rsp_item.status         = status_ff;
      rsp_item.thread_count   = 5'(cnt_ff);
   end

endmodule

// ===== tb/sv/tb_thread_table_scheduler_core.sv =====
`timescale 1ns / 1ps

module tb_thread_table_scheduler_core;
   import tts_pkg::*;

   localparam int TABLE_DEPTH    = DEF_MAX_ENTRIES;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_LEN   = 150;
   localparam int SETTLE_CYCLES  = 3;

   // op codes the block ignores
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   localparam logic [63:0] ALL_ONES = {64{1'b1}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   rsp_item_type          rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [63:0]           pwdata = '0;
   logic [63:0]           prdata;
   logic                  pready;

   thread_table_scheduler_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scheduler shadow state
   thr_state_type thr_state [TABLE_DEPTH];
   logic [63:0]   thr_context [TABLE_DEPTH];
   logic [63:0]   thr_stack [TABLE_DEPTH];
   logic [63:0]   thr_root [TABLE_DEPTH];
   logic [3:0]    cur_idx;
   logic [4:0]    n_used;
   logic [63:0]   cfg_root;
   logic [63:0]   cfg_stack;

   rsp_item_type  due_results[$];
   int            mismatch_count = 0;
   bit            idling_on = 1'b1;
   int            hold_left = 0;
   int            stall_left = 0;
   int            quiet_cycles = 0;

   function automatic void reset_model();
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         thr_state[i]   = TS_READY;
         thr_context[i] = '0;
         thr_stack[i]   = '0;
         thr_root[i]    = '0;
      end
      thr_state[0] = TS_RUNNING;
      cur_idx      = '0;
      n_used       = 5'd1;
      cfg_root     = KERNEL_ROOT_RESET;
      cfg_stack    = BOOT_STACK_RESET;
   endfunction

   // entry 0 reads its stack and root live from the registers
   function automatic logic [63:0] stack_of(int i);
      if (i == 0) return cfg_stack;
      return thr_stack[i];
   endfunction

   function automatic logic [63:0] root_of(int i);
      if (i == 0) return cfg_root;
      return thr_root[i];
   endfunction

   function automatic int prio_of(int i);
      if (i == 1) return 2;
      if (i == 0) return 0;
      return 1;
   endfunction

   // round-robin pick starting after the current entry, wrapping onto itself
   function automatic bit run_tick(logic [63:0] ctx, output int pick);
      int cur;
      int idx;
      int k;
      int n;
      pick = 0;
      n = int'(n_used);
      if (n <= 1) return 1'b0;
      cur = int'(cur_idx);
      thr_context[cur] = ctx;
      if (thr_state[cur] == TS_RUNNING) thr_state[cur] = TS_READY;
      idx = cur;
      for (k = 0; k < n; k++) begin
         idx = (idx + 1) % n;
         if (thr_state[idx] == TS_READY) begin
            thr_state[idx] = TS_RUNNING;
            cur_idx = 4'(idx);
            pick = idx;
            return 1'b1;
         end
      end
      // nothing ready: current keeps the cpu
      thr_state[cur] = TS_RUNNING;
      return 1'b0;
   endfunction

   // fixed-priority pick; a non-running current starts from entry 0 at lowest
   function automatic bit run_irq(logic [63:0] ctx, output int pick);
      int cur;
      int best;
      int best_prio;
      int i;
      int n;
      pick = 0;
      n = int'(n_used);
      if (n <= 1) return 1'b0;
      cur = int'(cur_idx);
      best = cur;
      best_prio = 0;
      if (thr_state[cur] == TS_RUNNING) best_prio = prio_of(cur);
      else best = 0;
      for (i = 0; i < n; i++) begin
         if (thr_state[i] == TS_READY && prio_of(i) > best_prio) begin
            best_prio = prio_of(i);
            best = i;
         end
      end
      if (best == cur) return 1'b0;
      thr_context[cur] = ctx;
      if (thr_state[cur] == TS_RUNNING) thr_state[cur] = TS_READY;
      thr_state[best] = TS_RUNNING;
      cur_idx = 4'(best);
      pick = best;
      return 1'b1;
   endfunction

   // apply one accepted beat and return the result it should produce
   function automatic rsp_item_type schedule_step(req_item_type item);
      rsp_item_type r;
      bit sw;
      int pick;
      int slot;
      r = '0;
      sw = 1'b0;
      pick = 0;
      case (item.op)
         OP_TICK: sw = run_tick(item.current_context, pick);
         OP_IRQ: sw = run_irq(item.current_context, pick);
         OP_BLOCK, OP_EXIT: begin
            if (item.op == OP_BLOCK) thr_state[cur_idx] = TS_BLOCKED;
            else thr_state[cur_idx] = TS_TERMINATED;
            sw = run_tick(item.current_context, pick);
         end
         OP_UNBLOCK: begin
            for (slot = 0; slot < int'(n_used); slot++) begin
               if (thr_state[slot] == TS_BLOCKED) thr_state[slot] = TS_READY;
            end
         end
         OP_ADD: begin
            if (int'(n_used) >= TABLE_DEPTH) begin
               r.status = 1'b1;
            end else begin
               slot = int'(n_used);
               thr_context[slot] = item.new_context;
               thr_stack[slot]   = item.new_stack_top;
               thr_root[slot]    = item.new_space_root;
               thr_state[slot]   = TS_READY;
               n_used = n_used + 5'd1;
            end
         end
         default: ;
      endcase
      r.switched       = sw;
      r.thread_index   = cur_idx;
      r.resume_context = sw ? thr_context[pick] : 64'h0;
      r.kernel_stack   = stack_of(int'(cur_idx));
      r.space_root     = sw ? root_of(pick) : 64'h0;
      r.thread_count   = n_used;
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // mostly short gaps, a few long ones
   function automatic int draw_gap();
      int r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] any64();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 64'h0;
      if (r == 1) return ALL_ONES;
      return {$urandom(), $urandom()};
   endfunction

   // result side: check each beat, then choose the next stall
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            flag_mismatch("result beat with none due, thread_index",
                          64'(rsp_item.thread_index), 64'h0);
         end else begin
            want = due_results.pop_front();
            if (rsp_item.switched !== want.switched)
               flag_mismatch("switched", 64'(rsp_item.switched), 64'(want.switched));
            if (rsp_item.thread_index !== want.thread_index)
               flag_mismatch("thread_index", 64'(rsp_item.thread_index),
                             64'(want.thread_index));
            if (rsp_item.resume_context !== want.resume_context)
               flag_mismatch("resume_context", rsp_item.resume_context,
                             want.resume_context);
            if (rsp_item.kernel_stack !== want.kernel_stack)
               flag_mismatch("kernel_stack", rsp_item.kernel_stack, want.kernel_stack);
            if (rsp_item.space_root !== want.space_root)
               flag_mismatch("space_root", rsp_item.space_root, want.space_root);
            if (rsp_item.status !== want.status)
               flag_mismatch("status", 64'(rsp_item.status), 64'(want.status));
            if (rsp_item.thread_count !== want.thread_count)
               flag_mismatch("thread_count", 64'(rsp_item.thread_count),
                             64'(want.thread_count));
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_left == 0) stall_left = draw_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: cycles without any beat moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // offer one beat; valid stays up until taken and after, unless a gap follows
   task automatic send_beat(req_item_type item);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_results.push_back(schedule_step(item));
   endtask

   task automatic send_op(logic [2:0] op);
      req_item_type item;
      item.op              = op;
      item.current_context = any64();
      item.new_context     = any64();
      item.new_stack_top   = any64();
      item.new_space_root  = any64();
      send_beat(item);
   endtask

   task automatic send_add(logic [63:0] fill);
      req_item_type item;
      item.op              = OP_ADD;
      item.current_context = ~fill;
      item.new_context     = fill;
      item.new_stack_top   = fill;
      item.new_space_root  = fill;
      send_beat(item);
   endtask

   // drop valid and wait until every due result has come back
   task automatic finish_outstanding();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic set_register(logic reg_sel, logic [63:0] value);
      finish_outstanding();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == CSR_KERNEL_ROOT) cfg_root = value;
      else cfg_stack = value;
   endtask

   function automatic req_item_type random_item(int exit_pct);
      req_item_type item;
      int r;
      item.current_context = any64();
      item.new_context     = any64();
      item.new_stack_top   = any64();
      item.new_space_root  = any64();
      r = $urandom_range(0, 99);
      if (r < exit_pct) item.op = OP_EXIT;
      else if (r < exit_pct + 6) item.op = OP_ADD;
      else if (r < exit_pct + 9) item.op = ($urandom_range(0, 1) != 0) ? OP_RSVD_7 : OP_RSVD_6;
      else if (r < 40) item.op = OP_TICK;
      else if (r < 65) item.op = OP_IRQ;
      else if (r < 83) item.op = OP_BLOCK;
      else item.op = OP_UNBLOCK;
      return item;
   endfunction

   // ignored op codes do not count toward the phase length
   task automatic run_phase(int n_items, int exit_pct);
      req_item_type item;
      int sent;
      sent = 0;
      while (sent < n_items) begin
         item = random_item(exit_pct);
         send_beat(item);
         if (item.op != OP_RSVD_6 && item.op != OP_RSVD_7) sent++;
      end
   endtask

   // single thread: picks do nothing, unused codes are ignored
   task automatic test_reset_defaults();
      send_op(OP_TICK);
      send_op(OP_IRQ);
      send_op(OP_RSVD_6);
      send_op(OP_RSVD_7);
   endtask

   // entry 0 follows the registers live
   task automatic test_config_extremes();
      set_register(CSR_KERNEL_ROOT, ALL_ONES);
      set_register(CSR_BOOT_STACK, ALL_ONES);
      send_op(OP_TICK);
      set_register(CSR_KERNEL_ROOT, 64'h0);
      set_register(CSR_BOOT_STACK, 64'h0);
      send_op(OP_IRQ);
   endtask

   task automatic test_thread_lifecycle();
      // block with one thread: current left blocked, no pick
      send_op(OP_BLOCK);
      send_op(OP_UNBLOCK);
      send_op(OP_BLOCK);
      send_add(ALL_ONES);
      // current not running: priority scan starts from entry 0
      send_op(OP_IRQ);
      send_op(OP_UNBLOCK);
      send_add(64'h0);
      send_op(OP_ADD);
      send_op(OP_TICK);
      // middle priority gives way to entry 1, which then keeps the cpu
      send_op(OP_IRQ);
      send_op(OP_IRQ);
      send_op(OP_TICK);
      send_op(OP_BLOCK);
      send_op(OP_EXIT);
      send_op(OP_UNBLOCK);
      send_op(OP_TICK);
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      int i;
      finish_outstanding();
      idling_on = 1'b0;
      hold_left = HOLD_OFF_LEN;
      for (i = 0; i < 10; i++) send_beat(random_item(0));
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      set_register(CSR_KERNEL_ROOT, {$urandom(), $urandom()});
      set_register(CSR_BOOT_STACK, {$urandom(), $urandom()});
      run_phase(370, 0);
      idling_on = 1'b0;
      set_register(CSR_KERNEL_ROOT, ALL_ONES);
      set_register(CSR_BOOT_STACK, 64'h0);
      run_phase(370, 1);
      idling_on = 1'b1;
      set_register(CSR_KERNEL_ROOT, 64'h0);
      set_register(CSR_BOOT_STACK, ALL_ONES);
      run_phase(370, 2);
      set_register(CSR_KERNEL_ROOT, {$urandom(), $urandom()});
      set_register(CSR_BOOT_STACK, {$urandom(), $urandom()});
      run_phase(370, 4);
   endtask

   initial begin
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_config_extremes();
      test_thread_lifecycle();
      test_backpressure();
      test_random_traffic();
      finish_outstanding();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tts_pkg.sv
hw/rtl/tts_csr.sv
hw/rtl/tts_ctrl.sv
hw/rtl/tts_dp.sv
hw/rtl/thread_table_scheduler_core.sv
tb/sv/tb_thread_table_scheduler_core.sv
